>>> hw/rtl/hpq_pkg.sv
package hpq_pkg;

  // Heap sizing
  localparam int unsigned Capacity = 1024;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned DataW    = 32;

  // Fixed field widths
  localparam int unsigned PosW     = 11;
  localparam int unsigned TotW     = 11;
  localparam int unsigned StatW    = 2;
  localparam int unsigned CmpW     = (CntW > PosW) ? CntW : PosW;

  typedef logic signed [DataW-1:0] word_t;
  typedef logic [AddrW-1:0]        addr_t;
  typedef logic [CntW-1:0]         cnt_t;

  // Operation codes
  localparam logic OpInsert = 1'b0;
  localparam logic OpDelete = 1'b1;

  // Status codes
  localparam logic [StatW-1:0] StDone   = 2'd0;
  localparam logic [StatW-1:0] StFull   = 2'd1;
  localparam logic [StatW-1:0] StBadPos = 2'd2;

  // Write request into the heap store
  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } wr_req_t;

endpackage

>>> hw/rtl/hpq_ram.sv
module hpq_ram (
  input  logic             clk_i,
  input  hpq_pkg::wr_req_t wr_i,
  input  hpq_pkg::addr_t   raddr_i,
  output hpq_pkg::word_t   rdata_o
);
  import hpq_pkg::*;

  word_t mem [Capacity];

  // Write one word
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hw/rtl/max_heap_priority_queue_unit.sv
// Binary max-heap of signed 32-bit words, up to 1024 entries.
// Command channel: drive operation_i, value_i, position_i and raise start
// while busy is low; the beat is taken at that edge. An insert appends the
// value and sifts it up; a delete takes out the entry at position_i (1 is
// the maximum), moves the last entry into the slot and sifts it up, then down.
// Each command gives exactly one result beat: done_o is high for one cycle
// with status_o, removed_value_o, top_value_o, is_empty_o and entry_total_o.
// The receiver cannot stall; the result must be taken in that cycle.
// The entries live in a single-port-read, single-port-write store with a
// registered read, so each sift-up level reads the parent, then compares
// and writes, and each sift-down level goes through left read, right read,
// then compare and write.
// busy stays high from the start of a command that is not refused until
// done_o rises, and a refused command leaves it low; a new command may be
// started in the done_o cycle.
// Reset empties the heap at once (count cleared); the store itself is not
// cleared, since only written slots are ever read.
module max_heap_priority_queue_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation_i,
  input  logic signed [hpq_pkg::DataW-1:0]    value_i,
  input  logic        [hpq_pkg::PosW-1:0]     position_i,
  output logic                                done_o,
  output logic        [hpq_pkg::StatW-1:0]    status_o,
  output logic signed [hpq_pkg::DataW-1:0]    removed_value_o,
  output logic signed [hpq_pkg::DataW-1:0]    top_value_o,
  output logic                                is_empty_o,
  output logic        [hpq_pkg::TotW-1:0]     entry_total_o
);
  import hpq_pkg::*;

  localparam int unsigned StW = 3;
  localparam logic [StW-1:0] S_IDLE   = 3'd0;
  localparam logic [StW-1:0] S_UP_RD  = 3'd1;
  localparam logic [StW-1:0] S_UP_CMP = 3'd2;
  localparam logic [StW-1:0] S_D_POS  = 3'd3;
  localparam logic [StW-1:0] S_D_LAST = 3'd4;
  localparam logic [StW-1:0] S_DN_RD  = 3'd5;
  localparam logic [StW-1:0] S_DN_L   = 3'd6;
  localparam logic [StW-1:0] S_DN_CMP = 3'd7;

  logic [StW-1:0]   state_q, state_d;
  cnt_t             count_q, count_d;
  logic             done_q, done_d;
  logic             del_q, del_d;
  logic             has_r_q, has_r_d;
  cnt_t             cur_q, cur_d;
  word_t            val_q, val_d;
  word_t            left_q, left_d;
  word_t            top_q;
  logic [StatW-1:0] status_q, status_d;
  word_t            removed_q, removed_d;

  wr_req_t          wr;
  addr_t            raddr;
  word_t            rdata;

  logic [CntW:0]    left_idx;
  logic [CntW:0]    right_idx;
  cnt_t             parent_idx;
  logic             pick_r;
  word_t            child_val;
  cnt_t             child_idx;

  hpq_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Child and parent slots of the hole
  assign left_idx   = {cur_q, 1'b0};
  assign right_idx  = left_idx + 1'b1;
  assign parent_idx = cur_q >> 1;
  assign pick_r     = has_r_q && (rdata > left_q);
  assign child_val  = pick_r ? rdata : left_q;
  assign child_idx  = pick_r ? CntW'(right_idx) : CntW'(left_idx);

  // Sequence one command over the store
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    done_d    = 1'b0;
    del_d     = del_q;
    has_r_d   = has_r_q;
    cur_d     = cur_q;
    val_d     = val_q;
    left_d    = left_q;
    status_d  = status_q;
    removed_d = removed_q;
    wr        = '0;
    raddr     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          removed_d = '0;
          status_d  = StDone;
          if (operation_i == OpInsert) begin
            if (count_q == CntW'(Capacity)) begin
              status_d = StFull;
              done_d   = 1'b1;
            end else begin
              count_d = count_q + 1'b1;
              cur_d   = count_q + 1'b1;
              val_d   = value_i;
              del_d   = 1'b0;
              state_d = S_UP_RD;
            end
          end else begin
            if (position_i == '0 || CmpW'(position_i) > CmpW'(count_q)) begin
              status_d = StBadPos;
              done_d   = 1'b1;
            end else begin
              cur_d   = CntW'(position_i);
              raddr   = AddrW'(CntW'(position_i) - 1'b1);
              del_d   = 1'b1;
              state_d = S_D_POS;
            end
          end
        end
      end
      S_D_POS: begin
        // Latch the removed word; unless it was the last entry, fetch the last entry
        removed_d = rdata;
        if (cur_q == count_q) begin
          count_d = count_q - 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          raddr   = AddrW'(count_q - 1'b1);
          state_d = S_D_LAST;
        end
      end
      S_D_LAST: begin
        val_d   = rdata;
        count_d = count_q - 1'b1;
        state_d = S_UP_RD;
      end
      S_UP_RD: begin
        if (cur_q == CntW'(1)) begin
          if (del_q) begin
            state_d = S_DN_RD;
          end else begin
            wr      = '{en: 1'b1, addr: AddrW'(cur_q - 1'b1), data: val_q};
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          raddr   = AddrW'(parent_idx - 1'b1);
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (val_q > rdata) begin
          // Pull the parent down into the hole
          wr      = '{en: 1'b1, addr: AddrW'(cur_q - 1'b1), data: rdata};
          cur_d   = parent_idx;
          state_d = S_UP_RD;
        end else if (del_q) begin
          state_d = S_DN_RD;
        end else begin
          wr      = '{en: 1'b1, addr: AddrW'(cur_q - 1'b1), data: val_q};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DN_RD: begin
        if (left_idx > {1'b0, count_q}) begin
          wr      = '{en: 1'b1, addr: AddrW'(cur_q - 1'b1), data: val_q};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          raddr   = AddrW'(left_idx - 1'b1);
          state_d = S_DN_L;
        end
      end
      S_DN_L: begin
        left_d  = rdata;
        has_r_d = (right_idx <= {1'b0, count_q});
        raddr   = AddrW'(right_idx - 1'b1);
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (child_val > val_q) begin
          // Lift the larger child into the hole
          wr      = '{en: 1'b1, addr: AddrW'(cur_q - 1'b1), data: child_val};
          cur_d   = child_idx;
          state_d = S_DN_RD;
        end else begin
          wr      = '{en: 1'b1, addr: AddrW'(cur_q - 1'b1), data: val_q};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    del_q     <= del_d;
    has_r_q   <= has_r_d;
    cur_q     <= cur_d;
    val_q     <= val_d;
    left_q    <= left_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    if (wr.en && wr.addr == '0) begin
      top_q <= wr.data;
    end
  end

  // Drive the result beat
  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign top_value_o     = (count_q != '0) ? top_q : '0;
  assign is_empty_o      = (count_q == '0);
  assign entry_total_o   = TotW'(count_q);

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count beyond capacity");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result beat while still working");

  a_start_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted command neither working nor answered");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> state_q != S_IDLE)
    else $error("store written while idle");

  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StFull) |-> count_q == CntW'(Capacity))
    else $error("insert refused while not full");

endmodule
